@@ rtl/ptcs_pkg.sv @@
package ptcs_pkg;

   localparam logic [2:0] TY_BYTE = 3'd0;
   localparam logic [2:0] TY_U16  = 3'd1;
   localparam logic [2:0] TY_I16  = 3'd2;
   localparam logic [2:0] TY_U32  = 3'd3;
   localparam logic [2:0] TY_I32  = 3'd4;
   localparam logic [2:0] TY_F32  = 3'd5;
   localparam logic [2:0] TY_F64  = 3'd6;
   // unused code; either register holding it forces a zero word
   localparam logic [2:0] TY_BAD  = 3'd7;

   localparam logic REG_SOURCE_TYPE = 1'b0;
   localparam logic REG_DEST_TYPE   = 1'b1;

   localparam int WORD_W = 64;
   localparam int MANT_W = 53;
   localparam int EXP_W  = 13;

   localparam logic [63:0] F64_QNAN = 64'h7FF8_0000_0000_0000;
   localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
   localparam logic [30:0] F32_INF_MAG = 31'h7F80_0000;

   // Fields that ride along with a beat unchanged by the arithmetic
   typedef struct packed {
      logic              pass;   // same source and dest type
      logic              bad;    // a type register holds an unused code
      logic [WORD_W-1:0] word;
      logic [2:0]        dst;
      logic              last;
   } side_type;

   typedef struct packed {
      logic                    sign;
      logic                    zero;
      logic                    inf;
      logic                    nan;
      logic [MANT_W-1:0]       r;
      logic signed [EXP_W-1:0] eb;
      logic [5:0]              lz;
      side_type                side;
   } dec_type;

   // Normalized value: magnitude = m * 2^(e-52), m[52] set when nonzero finite
   typedef struct packed {
      logic                    sign;
      logic                    zero;
      logic                    inf;
      logic                    nan;
      logic signed [EXP_W-1:0] e;
      logic [MANT_W-1:0]       m;
      side_type                side;
   } norm_type;

   typedef struct packed {
      logic                    sign;
      logic                    zero;
      logic                    inf;
      logic                    nan;
      logic signed [EXP_W-1:0] e;
      logic [MANT_W-1:0]       m;
      logic                    ovf;
      logic                    big;
      logic [31:0]             mag;
      logic [23:0]             kept;
      logic                    guard;
      logic                    sticky;
      logic [7:0]              ebase;
      side_type                side;
   } enc_type;

   function automatic logic [5:0] lead_zeros(input logic [MANT_W-1:0] r);
      logic [5:0] lz;
      lz = 6'd0;
      for (int i = 0; i < MANT_W; i++) begin
         if (r[i]) lz = 6'(MANT_W - 1 - i);
      end
      return lz;
   endfunction

   function automatic logic [WORD_W-1:0] type_mask(input logic [2:0] t);
      logic [WORD_W-1:0] m;
      case (t)
         TY_BYTE: m = 64'h0000_0000_0000_00FF;
         TY_U16, TY_I16: m = 64'h0000_0000_0000_FFFF;
         TY_U32, TY_I32, TY_F32: m = 64'h0000_0000_FFFF_FFFF;
         default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

@@ rtl/ptcs_if.sv @@
interface ptcs_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] source_word;
   logic        last_in;
   modport source (output valid, output source_word, output last_in, input ready);
   modport sink (input valid, input source_word, input last_in, output ready);
endinterface

interface ptcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] dest_word;
   logic        last_out;
   modport source (output valid, output dest_word, output last_out, input ready);
   modport sink (input valid, input dest_word, input last_out, output ready);
endinterface

@@ rtl/pixel_type_convert_saturate.sv @@
// channel   | dir | beat payload
// req_chan  | in  | source_word[63:0], last_in
// rsp_chan  | out | dest_word[63:0], last_out
// csr       | in  | csr_we, csr_index (0 source_type, 1 dest_type), csr_wdata[2:0]
// Four register stages: unpack + leading-one search, normalize, align,
// round/clamp/pack. One beat per cycle while the output is not stalled.
// Synchronous reset clears valid bits and both type registers to byte.
// Each stage advances when empty or when the next one moves, so a stalled
// output keeps filling the bubbles behind it.
module pixel_type_convert_saturate (
   input  logic        clock,
   input  logic        reset,
   ptcs_req_if.sink    req_chan,
   ptcs_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [2:0]  csr_wdata
);

   logic [2:0] src_ff, dst_ff;
   logic       mid_valid, mid_ready;
   ptcs_pkg::norm_type mid_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= ptcs_pkg::TY_BYTE;
         dst_ff <= ptcs_pkg::TY_BYTE;
      end else if (csr_we) begin
         if (csr_index == ptcs_pkg::REG_SOURCE_TYPE) src_ff <= csr_wdata;
         if (csr_index == ptcs_pkg::REG_DEST_TYPE) dst_ff <= csr_wdata;
      end
   end

   ptcs_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_word   (req_chan.source_word),
      .in_last   (req_chan.last_in),
      .src_type  (src_ff),
      .dst_type  (dst_ff),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   ptcs_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_word  (rsp_chan.dest_word),
      .out_last  (rsp_chan.last_out)
   );

endmodule

@@ rtl/ptcs_decode.sv @@
module ptcs_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [63:0]        in_word,
   input  logic               in_last,
   input  logic [2:0]         src_type,
   input  logic [2:0]         dst_type,
   output logic               out_valid,
   input  logic               out_ready,
   output ptcs_pkg::norm_type out_data
);

   ptcs_pkg::dec_type  dec_in, dec_ff;
   ptcs_pkg::norm_type norm_in, norm_ff;
   logic v1_ff, v2_ff, rdy1, rdy2;
   logic [31:0] ival;
   logic        ineg;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // stage 1: unpack the source word and find the leading one
   always_comb begin
      dec_in = '0;
      ival   = 32'd0;
      ineg   = 1'b0;
      dec_in.side.bad  = (src_type == ptcs_pkg::TY_BAD) || (dst_type == ptcs_pkg::TY_BAD);
      dec_in.side.pass = (src_type == dst_type);
      dec_in.side.word = in_word;
      dec_in.side.dst  = dst_type;
      dec_in.side.last = in_last;
      case (src_type)
         ptcs_pkg::TY_BYTE: ival = {24'd0, in_word[7:0]};
         ptcs_pkg::TY_U16:  ival = {16'd0, in_word[15:0]};
         ptcs_pkg::TY_I16: begin
            ineg = in_word[15];
            ival = ineg ? 32'(17'h10000 - {1'b0, in_word[15:0]}) : {16'd0, in_word[15:0]};
         end
         ptcs_pkg::TY_U32:  ival = in_word[31:0];
         ptcs_pkg::TY_I32: begin
            ineg = in_word[31];
            ival = ineg ? (~in_word[31:0] + 32'd1) : in_word[31:0];
         end
         default: ival = 32'd0;
      endcase
      case (src_type)
         ptcs_pkg::TY_F32: begin
            dec_in.sign = in_word[31];
            if (in_word[30:23] == 8'hFF) begin
               dec_in.inf = (in_word[22:0] == 23'd0);
               dec_in.nan = (in_word[22:0] != 23'd0);
            end else if (in_word[30:23] == 8'h00) begin
               dec_in.r  = {1'b0, in_word[22:0], 29'd0};
               dec_in.eb = -13'sd126;
            end else begin
               dec_in.r  = {1'b1, in_word[22:0], 29'd0};
               dec_in.eb = $signed({5'd0, in_word[30:23]}) - 13'sd127;
            end
         end
         ptcs_pkg::TY_F64: begin
            dec_in.sign = in_word[63];
            if (in_word[62:52] == 11'h7FF) begin
               dec_in.inf = (in_word[51:0] == 52'd0);
               dec_in.nan = (in_word[51:0] != 52'd0);
            end else if (in_word[62:52] == 11'h000) begin
               dec_in.r  = {1'b0, in_word[51:0]};
               dec_in.eb = -13'sd1022;
            end else begin
               dec_in.r  = {1'b1, in_word[51:0]};
               dec_in.eb = $signed({2'd0, in_word[62:52]}) - 13'sd1023;
            end
         end
         default: begin
            dec_in.sign = ineg;
            dec_in.r    = {ival, 21'd0};
            dec_in.eb   = 13'sd31;
         end
      endcase
      dec_in.zero = !dec_in.inf && !dec_in.nan && (dec_in.r == '0);
      dec_in.lz   = ptcs_pkg::lead_zeros(dec_in.r);
   end

   // stage 2: normalize
   always_comb begin
      norm_in.sign = dec_ff.sign;
      norm_in.zero = dec_ff.zero;
      norm_in.inf  = dec_ff.inf;
      norm_in.nan  = dec_ff.nan;
      norm_in.e    = dec_ff.eb - $signed({7'd0, dec_ff.lz});
      norm_in.m    = dec_ff.r << dec_ff.lz;
      norm_in.side = dec_ff.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
      end
      if (rdy1 && in_valid) dec_ff <= dec_in;
      if (rdy2 && v1_ff) norm_ff <= norm_in;
   end

   assign out_valid = v2_ff;
   assign out_data  = norm_ff;

endmodule

@@ rtl/ptcs_encode.sv @@
module ptcs_encode (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ptcs_pkg::norm_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [63:0]        out_word,
   output logic               out_last
);

   ptcs_pkg::enc_type enc_in, enc_ff;
   logic [63:0] word_in, word_ff;
   logic        last_ff;
   logic v1_ff, v2_ff, rdy1, rdy2;
   logic [5:0]  shamt, tot;
   logic signed [12:0] sh;
   logic [52:0] t, smask;
   logic [24:0] rnd;
   logic [30:0] f32mag;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // stage 3: alignment for integer truncation and float32 rounding
   always_comb begin
      enc_in.sign = in_data.sign;
      enc_in.zero = in_data.zero;
      enc_in.inf  = in_data.inf;
      enc_in.nan  = in_data.nan;
      enc_in.e    = in_data.e;
      enc_in.m    = in_data.m;
      enc_in.side = in_data.side;
      enc_in.big  = in_data.inf || (!in_data.zero && (in_data.e > 13'sd31));
      enc_in.ovf  = in_data.inf || (!in_data.zero && (in_data.e > 13'sd127));
      shamt = 6'(13'sd52 - in_data.e);
      if (in_data.zero || in_data.nan || in_data.inf || in_data.e < 13'sd0
          || in_data.e > 13'sd31)
         enc_in.mag = 32'd0;
      else
         enc_in.mag = 32'(in_data.m >> shamt);
      sh = -13'sd126 - in_data.e;
      if (in_data.e >= -13'sd126) begin
         tot = 6'd29;
         enc_in.ebase = 8'(in_data.e + 13'sd126);
      end else begin
         tot = (sh > 13'sd25) ? 6'd54 : 6'(13'sd29 + sh);
         enc_in.ebase = 8'd0;
      end
      t = in_data.m >> (tot - 6'd1);
      smask = (53'd1 << (tot - 6'd1)) - 53'd1;
      enc_in.kept   = t[24:1];
      enc_in.guard  = t[0];
      enc_in.sticky = |(in_data.m & smask);
   end

   // stage 4: round, clamp and pack
   always_comb begin
      word_in = 64'd0;
      // carry out of the rounding bumps the exponent
      rnd     = {1'b0, enc_ff.kept}
                + {24'd0, enc_ff.guard && (enc_ff.sticky || enc_ff.kept[0])};
      f32mag  = {enc_ff.ebase, 23'd0} + {6'd0, rnd};
      if (enc_ff.side.bad) begin
         word_in = 64'd0;
      end else if (enc_ff.side.pass) begin
         word_in = enc_ff.side.word & ptcs_pkg::type_mask(enc_ff.side.dst);
      end else if (enc_ff.nan && enc_ff.side.dst != ptcs_pkg::TY_F32
                   && enc_ff.side.dst != ptcs_pkg::TY_F64) begin
         word_in = 64'd0;
      end else begin
         case (enc_ff.side.dst)
            ptcs_pkg::TY_BYTE:
               word_in = enc_ff.sign ? 64'd0 :
                  (enc_ff.big || enc_ff.mag > 32'd255) ? 64'd255 : {32'd0, enc_ff.mag};
            ptcs_pkg::TY_U16:
               word_in = enc_ff.sign ? 64'd0 :
                  (enc_ff.big || enc_ff.mag > 32'd65535) ? 64'd65535 : {32'd0, enc_ff.mag};
            ptcs_pkg::TY_U32:
               word_in = enc_ff.sign ? 64'd0 :
                  (enc_ff.big ? 64'h0000_0000_FFFF_FFFF : {32'd0, enc_ff.mag});
            ptcs_pkg::TY_I16: begin
               if (!enc_ff.sign)
                  word_in = (enc_ff.big || enc_ff.mag > 32'd32767) ? 64'h7FFF
                            : {32'd0, enc_ff.mag};
               else
                  word_in = (enc_ff.big || enc_ff.mag > 32'd32768) ? 64'h8000
                            : {48'd0, 16'(32'd0 - enc_ff.mag)};
            end
            ptcs_pkg::TY_I32: begin
               if (!enc_ff.sign)
                  word_in = (enc_ff.big || enc_ff.mag > 32'h7FFF_FFFF) ? 64'h7FFF_FFFF
                            : {32'd0, enc_ff.mag};
               else
                  word_in = (enc_ff.big || enc_ff.mag > 32'h7FFF_FFFF) ? 64'h8000_0001
                            : {32'd0, 32'd0 - enc_ff.mag};
            end
            ptcs_pkg::TY_F32: begin
               if (enc_ff.nan)
                  word_in = {32'd0, ptcs_pkg::F32_QNAN};
               else if (enc_ff.zero)
                  word_in = {32'd0, enc_ff.sign, 31'd0};
               else if (enc_ff.ovf || f32mag >= ptcs_pkg::F32_INF_MAG)
                  word_in = {32'd0, enc_ff.sign, ptcs_pkg::F32_INF_MAG};
               else
                  word_in = {32'd0, enc_ff.sign, f32mag};
            end
            ptcs_pkg::TY_F64: begin
               if (enc_ff.nan)
                  word_in = ptcs_pkg::F64_QNAN;
               else if (enc_ff.inf)
                  word_in = {enc_ff.sign, 11'h7FF, 52'd0};
               else if (enc_ff.zero)
                  word_in = {enc_ff.sign, 63'd0};
               else
                  word_in = {enc_ff.sign, 11'(enc_ff.e + 13'sd1023), enc_ff.m[51:0]};
            end
            default: word_in = 64'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
      end
      if (rdy1 && in_valid) enc_ff <= enc_in;
      if (rdy2 && v1_ff) begin
         word_ff <= word_in;
         last_ff <= enc_ff.side.last;
      end
   end

   assign out_valid = v2_ff;
   assign out_word  = word_ff;
   assign out_last  = last_ff;

endmodule

@@ rtl/ptcs_checker.sv @@
module ptcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] dest_word,
   input logic        csr_we,
   input logic        csr_index,
   input logic [2:0]  csr_wdata
);

   logic [2:0] src_ff, dst_ff;

   // shadow of the type registers; the user must write them only while idle, which the block itself does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= ptcs_pkg::TY_BYTE;
         dst_ff <= ptcs_pkg::TY_BYTE;
      end else if (csr_we) begin
         if (csr_index == ptcs_pkg::REG_SOURCE_TYPE) src_ff <= csr_wdata;
         if (csr_index == ptcs_pkg::REG_DEST_TYPE) dst_ff <= csr_wdata;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_bad_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (src_ff == ptcs_pkg::TY_BAD || dst_ff == ptcs_pkg::TY_BAD)
      |-> dest_word == 64'd0)
      else $error("unused type code gave nonzero word");

   a_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && src_ff != ptcs_pkg::TY_BAD && dst_ff != ptcs_pkg::TY_F64
      |-> dest_word[63:32] == 32'd0)
      else $error("narrow destination word not zero-extended");

endmodule

bind pixel_type_convert_saturate ptcs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .dest_word (rsp_chan.dest_word),
   .csr_we    (csr_we),
   .csr_index (csr_index),
   .csr_wdata (csr_wdata)
);

@@ bench/tb_pixel_type_convert_saturate.sv @@
class pixel_checker;
   logic [2:0]  src_ty;
   logic [2:0]  dst_ty;
   logic [64:0] pending[$];
   int          errors;

   function new();
      src_ty = ptcs_pkg::TY_BYTE;
      dst_ty = ptcs_pkg::TY_BYTE;
      errors = 0;
   endfunction

   // round toward zero, exact for the integer ranges used here
   function longint trunc_zero(real d);
      longint t;
      t = longint'(d);
      if (d >= 0.0 && real'(t) > d) t = t - 1;
      else if (d < 0.0 && real'(t) < d) t = t + 1;
      return t;
   endfunction

   // source word as exact double bit pattern
   function logic [63:0] as_double(logic [2:0] t, logic [63:0] w);
      real r;
      case (t)
         ptcs_pkg::TY_BYTE: return $realtobits(real'(w[7:0]));
         ptcs_pkg::TY_U16:  return $realtobits(real'(w[15:0]));
         ptcs_pkg::TY_I16:  return $realtobits(real'($signed(w[15:0])));
         ptcs_pkg::TY_U32:  return $realtobits(real'(w[31:0]));
         ptcs_pkg::TY_I32:  return $realtobits(real'($signed(w[31:0])));
         ptcs_pkg::TY_F32: begin
            if (w[30:23] == 8'hFF) return {w[31], 11'h7FF, w[22:0], 29'b0};
            if (w[30:23] == 8'h00) begin
               if (w[22:0] == 23'd0) return {w[31], 63'b0};
               r = real'(w[22:0]) * 2.0 ** (-149);
               if (w[31]) r = -r;
               return $realtobits(r);
            end
            return {w[31], 11'(w[30:23] + 11'd896), w[22:0], 29'b0};
         end
         default: return w;
      endcase
   endfunction

   function logic [31:0] to_single(logic [63:0] b);
      int          ue, shift;
      logic [63:0] sig, q, rem, half, mag;
      if (b[62:52] == 11'h7FF) return {b[63], 8'hFF, 23'b0};
      if (b[62:52] == 11'h000) return {b[63], 31'b0};
      ue = int'(b[62:52]) - 1023;
      if (ue >= 128) return {b[63], 8'hFF, 23'b0};
      sig = {11'b0, 1'b1, b[51:0]};
      shift = (ue >= -126) ? 29 : -(ue + 97);
      if (shift >= 55) return {b[63], 31'b0};
      q = sig >> shift;
      rem = sig & ((64'd1 << shift) - 64'd1);
      half = 64'd1 << (shift - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      mag = (ue >= -126) ? ((64'(ue + 126) << 23) + q) : q;
      if (mag >= 64'h7F80_0000) mag = 64'h7F80_0000;
      return {b[63], mag[30:0]};
   endfunction

   function logic [63:0] convert(logic [63:0] w);
      logic [63:0] b;
      logic        nan;
      real         d;
      if (src_ty > ptcs_pkg::TY_F64 || dst_ty > ptcs_pkg::TY_F64) return 64'd0;
      if (src_ty == dst_ty) return w & ptcs_pkg::type_mask(src_ty);
      b = as_double(src_ty, w);
      nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
      d = $bitstoreal(b);
      case (dst_ty)
         ptcs_pkg::TY_BYTE: begin
            if (nan || d < 0.0) return 64'd0;
            if (d > 255.0) return 64'd255;
            return 64'(trunc_zero(d));
         end
         ptcs_pkg::TY_U16: begin
            if (nan || d < 0.0) return 64'd0;
            if (d > 65535.0) return 64'd65535;
            return 64'(trunc_zero(d));
         end
         ptcs_pkg::TY_I16: begin
            if (nan) return 64'd0;
            if (d < -32768.0) return 64'h8000;
            if (d > 32767.0) return 64'h7FFF;
            return {48'd0, 16'(trunc_zero(d))};
         end
         ptcs_pkg::TY_U32: begin
            if (nan || d < 0.0) return 64'd0;
            if (d > 4294967295.0) return 64'hFFFF_FFFF;
            return 64'(trunc_zero(d));
         end
         ptcs_pkg::TY_I32: begin
            if (nan) return 64'd0;
            if (d < -2147483647.0) return 64'h8000_0001;
            if (d > 2147483647.0) return 64'h7FFF_FFFF;
            return {32'd0, 32'(trunc_zero(d))};
         end
         ptcs_pkg::TY_F32: begin
            if (nan) return 64'(ptcs_pkg::F32_QNAN);
            return 64'(to_single(b));
         end
         default: begin
            if (nan) return ptcs_pkg::F64_QNAN;
            return b;
         end
      endcase
   endfunction

   function void note_input(logic [63:0] w, logic last);
      pending.push_back({last, convert(w)});
   endfunction

   function void check_result(logic [63:0] w, logic last);
      logic [64:0] exp_beat;
      if (pending.size() == 0) begin
         $display("%0t: unexpected beat word=%h last=%b", $time, w, last);
         errors++;
         return;
      end
      exp_beat = pending.pop_front();
      if (w !== exp_beat[63:0]) begin
         $display("%0t: dest_word expected %h actual %h", $time, exp_beat[63:0], w);
         errors++;
      end
      if (last !== exp_beat[64]) begin
         $display("%0t: last_out expected %b actual %b", $time, exp_beat[64], last);
         errors++;
      end
   endfunction
endclass

module tb_pixel_type_convert_saturate;
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_index = ptcs_pkg::REG_SOURCE_TYPE;
   logic [2:0] csr_wdata = 3'd0;
   int         snd_idle = 23;
   int         rcv_idle = 53;
   bit         hold_req = 1'b0;
   longint     cycles = 0;
   pixel_checker chk = new();

   ptcs_req_if req();
   ptcs_rsp_if rsp();

   pixel_type_convert_saturate uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req),
      .rsp_chan(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.source_word = 64'd0;
      req.last_in = 1'b0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: check, then choose next ready
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) chk.check_result(rsp.dest_word, rsp.last_out);
         if (hold_req) begin
            rsp.ready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_req = 1'b0;
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= rcv_idle);
         end
      end
   end

   task automatic send_beat(logic [63:0] w, logic last);
      while ($urandom_range(0, 99) < snd_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.source_word <= w;
      req.last_in <= last;
      do @(posedge clock); while (!req.ready);
      chk.note_input(w, last);
   endtask

   task automatic set_types(logic [2:0] s, logic [2:0] d);
      req.valid <= 1'b0;
      @(posedge clock);
      while (chk.pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= ptcs_pkg::REG_SOURCE_TYPE;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= ptcs_pkg::REG_DEST_TYPE;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      chk.src_ty = s;
      chk.dst_ty = d;
   endtask

   function automatic logic [63:0] pick_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: ;
         1: begin
            case ($urandom_range(0, 13))
               0: w = 64'd0;
               1: w = '1;
               2: w = 64'h8000_0000;
               3: w = 64'h7FFF_FFFF;
               4: w = 64'h7F80_0000;
               5: w = 64'hFF80_0000;
               6: w = 64'h7FC0_0001;
               7: w = 64'h4F80_0000;
               8: w = 64'h7FF0_0000_0000_0000;
               9: w = 64'h41EF_FFFF_FFE0_0000;
               10: w = 64'h47EF_FFFF_F000_0000;
               11: w = 64'h47EF_FFFF_E000_0000;
               12: w = 64'hC1E0_0000_0000_0000;
               default: w = 64'h8000;
            endcase
         end
         2: w[62:52] = 11'(1023 + $urandom_range(0, 300) - 160);
         default: w[30:23] = 8'(127 + $urandom_range(0, 60) - 30);
      endcase
      return w;
   endfunction

   initial begin
      logic [63:0] f64_cases[12] = '{64'h0, 64'h8000_0000_0000_0000,
         64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'hFFF8_0000_0000_0001,
         64'h47EF_FFFF_F000_0000, 64'h47EF_FFFF_EFFF_FFFF, 64'h36A0_0000_0000_0000,
         64'h3690_0000_0000_0000, 64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000,
         64'h0000_0000_0000_0001};
      logic [63:0] f32_cases[8] = '{64'hFFFF_FFFF_CF00_0000, 64'hCF00_0001,
         64'h4F00_0000, 64'h7FC0_0000, 64'h0000_0001, 64'hBF7F_FFFF,
         64'h4F80_0000, 64'hFF80_0000};
      int p;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state: byte pass-through, upper bits dropped
      send_beat('1, 1'b1);
      send_beat(64'h1234_5678_9ABC_DE80, 1'b0);
      set_types(ptcs_pkg::TY_F64, ptcs_pkg::TY_F32);
      foreach (f64_cases[i]) send_beat(f64_cases[i], i[0]);
      set_types(ptcs_pkg::TY_F32, ptcs_pkg::TY_I32);
      foreach (f32_cases[i]) send_beat(f32_cases[i], i[0]);

      for (p = 0; p < 64; p++) begin
         set_types(3'(p / 8), 3'(p % 8));
         if (p < 21) begin
            snd_idle = 23; rcv_idle = 53;
         end else if (p < 42) begin
            snd_idle = 53; rcv_idle = 23;
         end else begin
            snd_idle = 0; rcv_idle = 0;
         end
         if (p == 45) hold_req = 1'b1;
         repeat (22) send_beat(pick_word(), 1'($urandom));
      end
      req.valid <= 1'b0;
      while (chk.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (chk.errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
